@@ sv/dpw_pkg.sv @@
// ----------------------------------------------------------------------------
// dpw_pkg: shared definitions for the depth pixel to world point block
// Register map, reset values, output limits, status types and width helpers.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // default geometry of the pixel word
  localparam int COORD_BITS_DEF = 10;
  localparam int DEPTH_BITS_DEF = 16;

  // configuration port: 64-bit data, registers on 8-byte strides
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_ADDR_LSB = 3;

  // queue between front and back: 2^QUEUE_AW words
  localparam int QUEUE_AW = 2;

  // output coordinate limits
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // register indexes
  typedef enum logic [2:0] {
    REG_PRINCIPAL_X = 3'd0,
    REG_PRINCIPAL_Y = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_ROT_ROW0    = 3'd4,
    REG_ROT_ROW1    = 3'd5,
    REG_ROT_ROW2    = 3'd6,
    REG_TRANSLATION = 3'd7
  } reg_idx_t;

  // reset values: identity rotation, zero translation
  localparam logic [11:0] RST_PRINCIPAL_X = 12'd651;
  localparam logic [11:0] RST_PRINCIPAL_Y = 12'd507;
  localparam logic [23:0] RST_INV_FOCAL_X = 24'd32388;
  localparam logic [23:0] RST_INV_FOCAL_Y = 24'd32326;
  localparam logic [47:0] RST_ROT_ROW0    = 48'h4000_0000_0000;
  localparam logic [47:0] RST_ROT_ROW1    = 48'h0000_4000_0000;
  localparam logic [47:0] RST_ROT_ROW2    = 48'h0000_0000_4000;
  localparam logic [62:0] RST_TRANSLATION = 63'd0;

  // configuration values as seen by the datapath
  typedef struct packed {
    logic [11:0] principal_x_half;
    logic [11:0] principal_y_half;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [47:0] rotation_row0;
    logic [47:0] rotation_row1;
    logic [47:0] rotation_row2;
    logic [62:0] translation_packed;
  } cfg_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // signed width of 2*coord - principal (principal is 12 bits unsigned)
  function automatic int dx_width(input int coord_bits);
    return ((coord_bits + 1 > 12) ? coord_bits + 1 : 12) + 1;
  endfunction

  // queue word: dx, dy, depth, red/green/blue
  function automatic int item_width(input int coord_bits, input int depth_bits);
    return 2 * dx_width(coord_bits) + depth_bits + 24;
  endfunction

endpackage

@@ sv/depth_pixel_to_world_point.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point: RGB-D pixel to world point
// Pinhole back-projection followed by a configured rigid transform.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on a queue-style port: a word is taken at a clock edge with
//   push high and full low. Pixels with zero depth are dropped and give no
//   result. Results leave on a queue-style port: while empty is low the
//   oldest world point (millimetres, saturated to 24 bits) and its colour are
//   on the outputs, and the word is taken at an edge with pop high.
//   Throughput is one pixel per clock while the output word is not held;
//   every stage holds at most one multiplier bank, and the six-stage
//   transform pipeline sets the figure. An accepted pixel is loaded into
//   the intake register, written to the queue, then runs the six stages.
//   With a result waiting and pop low, the pipeline holds in place and
//   the four-word queue plus the intake register take pixels until full rises.
//   Reset (rst, synchronous) empties the queue and pipeline and loads the
//   default intrinsics, identity rotation and zero translation.
//   Registers are written over the APB-style port, 8 bytes per register;
//   users must write only while no pixel is in flight; the block won't enforce.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point #(
  parameter int COORD_BITS = dpw_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpw_pkg::DEPTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // pixel side
  input  logic                            push,
  output logic                            full,
  input  logic [COORD_BITS-1:0]           column,
  input  logic [COORD_BITS-1:0]           row,
  input  logic [DEPTH_BITS-1:0]           raw_depth,
  input  logic [7:0]                      blue_in,
  input  logic [7:0]                      green_in,
  input  logic [7:0]                      red_in,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic signed [23:0]              world_x,
  output logic signed [23:0]              world_y,
  output logic signed [23:0]              world_z,
  output logic [7:0]                      red_out,
  output logic [7:0]                      green_out,
  output logic [7:0]                      blue_out,
  output logic                            saturated,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dpw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int QW = dpw_pkg::item_width(COORD_BITS, DEPTH_BITS);

  dpw_pkg::cfg_t      cfg;
  dpw_pkg::q_status_t q_status;
  logic               q_wr, q_rd;
  logic [QW-1:0]      q_wdata, q_rdata;

  // register file
  dpw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // intake and classification
  dpw_front #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .column    (column),
    .row       (row),
    .raw_depth (raw_depth),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .cfg       (cfg),
    .q_status  (q_status),
    .q_wr      (q_wr),
    .q_data    (q_wdata)
  );

  // decoupling queue
  dpw_queue #(
    .WIDTH (QW),
    .AW    (dpw_pkg::QUEUE_AW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .status  (q_status)
  );

  // projection and transform
  dpw_back #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .q_rd      (q_rd),
    .q_data    (q_rdata),
    .empty     (empty),
    .pop       (pop),
    .world_x   (world_x),
    .world_y   (world_y),
    .world_z   (world_z),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .saturated (saturated)
  );

endmodule

@@ sv/dpw_cfg.sv @@
// ----------------------------------------------------------------------------
// dpw_cfg: configuration register file
// APB-style slave, zero wait states; one register per 8-byte slot, 63 bits max.
// ----------------------------------------------------------------------------
module dpw_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dpw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [dpw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output dpw_pkg::cfg_t                     cfg
);

  dpw_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = dpw_pkg::reg_idx_t'(paddr[dpw_pkg::CFG_ADDR_W-1:dpw_pkg::CFG_ADDR_LSB]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes, masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.principal_x_half   <= dpw_pkg::RST_PRINCIPAL_X;
      cfg.principal_y_half   <= dpw_pkg::RST_PRINCIPAL_Y;
      cfg.inv_focal_x        <= dpw_pkg::RST_INV_FOCAL_X;
      cfg.inv_focal_y        <= dpw_pkg::RST_INV_FOCAL_Y;
      cfg.rotation_row0      <= dpw_pkg::RST_ROT_ROW0;
      cfg.rotation_row1      <= dpw_pkg::RST_ROT_ROW1;
      cfg.rotation_row2      <= dpw_pkg::RST_ROT_ROW2;
      cfg.translation_packed <= dpw_pkg::RST_TRANSLATION;
    end else if (wr_en) begin
      case (idx)
        dpw_pkg::REG_PRINCIPAL_X: cfg.principal_x_half   <= pwdata[11:0];
        dpw_pkg::REG_PRINCIPAL_Y: cfg.principal_y_half   <= pwdata[11:0];
        dpw_pkg::REG_INV_FOCAL_X: cfg.inv_focal_x        <= pwdata[23:0];
        dpw_pkg::REG_INV_FOCAL_Y: cfg.inv_focal_y        <= pwdata[23:0];
        dpw_pkg::REG_ROT_ROW0:    cfg.rotation_row0      <= pwdata[47:0];
        dpw_pkg::REG_ROT_ROW1:    cfg.rotation_row1      <= pwdata[47:0];
        dpw_pkg::REG_ROT_ROW2:    cfg.rotation_row2      <= pwdata[47:0];
        dpw_pkg::REG_TRANSLATION: cfg.translation_packed <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      dpw_pkg::REG_PRINCIPAL_X: prdata = 64'(cfg.principal_x_half);
      dpw_pkg::REG_PRINCIPAL_Y: prdata = 64'(cfg.principal_y_half);
      dpw_pkg::REG_INV_FOCAL_X: prdata = 64'(cfg.inv_focal_x);
      dpw_pkg::REG_INV_FOCAL_Y: prdata = 64'(cfg.inv_focal_y);
      dpw_pkg::REG_ROT_ROW0:    prdata = 64'(cfg.rotation_row0);
      dpw_pkg::REG_ROT_ROW1:    prdata = 64'(cfg.rotation_row1);
      dpw_pkg::REG_ROT_ROW2:    prdata = 64'(cfg.rotation_row2);
      dpw_pkg::REG_TRANSLATION: prdata = 64'(cfg.translation_packed);
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ sv/dpw_front.sv @@
// ----------------------------------------------------------------------------
// dpw_front: pixel intake
// Accepts pixels, drops those without a depth sample, forms the offsets from
// the principal point and hands the word to the queue.
// ----------------------------------------------------------------------------
module dpw_front #(
  parameter int COORD_BITS = dpw_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpw_pkg::DEPTH_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [COORD_BITS-1:0]   column,
  input  logic [COORD_BITS-1:0]   row,
  input  logic [DEPTH_BITS-1:0]   raw_depth,
  input  logic [7:0]              blue_in,
  input  logic [7:0]              green_in,
  input  logic [7:0]              red_in,
  input  dpw_pkg::cfg_t           cfg,
  input  dpw_pkg::q_status_t      q_status,
  output logic                    q_wr,
  output logic [dpw_pkg::item_width(COORD_BITS, DEPTH_BITS)-1:0] q_data
);

  localparam int DXW = dpw_pkg::dx_width(COORD_BITS);

  logic                  f_valid;
  logic                  f_adv;
  logic signed [DXW-1:0] dx, dy;
  logic signed [DXW-1:0] dx_next, dy_next;
  logic [DEPTH_BITS-1:0] z;
  logic [23:0]           color;

  assign f_adv = !f_valid || !q_status.full;
  assign full  = !f_adv;
  assign q_wr  = f_valid && !q_status.full;
  assign q_data = {dx, dy, z, color};

  // offsets in half-pixel units, exact
  assign dx_next = DXW'($signed({1'b0, column, 1'b0})) -
                   DXW'($signed({1'b0, cfg.principal_x_half}));
  assign dy_next = DXW'($signed({1'b0, row, 1'b0})) -
                   DXW'($signed({1'b0, cfg.principal_y_half}));

  // intake register; a zero depth never becomes valid
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_adv) begin
      f_valid <= push && (raw_depth != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv && push) begin
      dx    <= dx_next;
      dy    <= dy_next;
      z     <= raw_depth;
      color <= {red_in, green_in, blue_in};
    end
  end

endmodule

@@ sv/dpw_queue.sv @@
// ----------------------------------------------------------------------------
// dpw_queue: short word queue between front and back
// Register-based, first word visible at the head while not empty.
// ----------------------------------------------------------------------------
module dpw_queue #(
  parameter int WIDTH = 64,
  parameter int AW    = dpw_pkg::QUEUE_AW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               rd_en,
  output logic [WIDTH-1:0]   rd_data,
  output dpw_pkg::q_status_t status
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign rd_data      = mem[rd_ptr];
  assign status.full  = (count == (AW+1)'(DEPTH));
  assign status.empty = (count == '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue fill level above depth");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !status.full || rd_en)
    else $error("queue written while full");
`endif

endmodule

@@ sv/dpw_back.sv @@
// ----------------------------------------------------------------------------
// dpw_back: projection and transform pipeline
// Six stages: depth scale, focal scale, rounding, rotation products,
// row sums with translation, round and clamp into the output register.
// ----------------------------------------------------------------------------
module dpw_back #(
  parameter int COORD_BITS = dpw_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpw_pkg::DEPTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dpw_pkg::cfg_t        cfg,
  input  dpw_pkg::q_status_t   q_status,
  output logic                 q_rd,
  input  logic [dpw_pkg::item_width(COORD_BITS, DEPTH_BITS)-1:0] q_data,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [23:0]   world_x,
  output logic signed [23:0]   world_y,
  output logic signed [23:0]   world_z,
  output logic [7:0]           red_out,
  output logic [7:0]           green_out,
  output logic [7:0]           blue_out,
  output logic                 saturated
);

  localparam int DXW  = dpw_pkg::dx_width(COORD_BITS);
  localparam int QW   = dpw_pkg::item_width(COORD_BITS, DEPTH_BITS);
  localparam int DZW  = DXW + DEPTH_BITS + 1;   // offset times depth
  localparam int PW   = DZW + 25;               // times reciprocal focal length
  localparam int CAMW = PW - 16;                // camera point, Q.8
  localparam int RPW  = CAMW + 16;              // rotation product
  localparam int ACCW = RPW + 3;                // row sum
  localparam int WW   = ACCW - 22;              // row sum after rounding shift
  localparam int CAM_SHIFT = 17;
  localparam logic signed [PW:0] CAM_HALF = (PW+1)'(1) << (CAM_SHIFT - 1);
  localparam logic signed [WW-1:0] W_MAX = WW'(dpw_pkg::OUT_MAX);
  localparam logic signed [WW-1:0] W_MIN = WW'(dpw_pkg::OUT_MIN);

  logic                  en;
  logic [5:0]            vld;
  logic [23:0]           color_pipe [6];

  logic signed [DXW-1:0] q_dx, q_dy;
  logic [DEPTH_BITS-1:0] q_z;

  logic signed [DZW-1:0]  dzx, dzy;
  logic signed [CAMW-1:0] camz1, camz2;
  logic signed [PW-1:0]   px, py;
  logic signed [PW:0]     sum_x, sum_y;
  logic signed [CAMW-1:0] cam [3];
  logic signed [15:0]     rot [3][3];
  logic signed [RPW-1:0]  prod [3][3];
  logic signed [42:0]     tterm [3];
  logic signed [ACCW-1:0] acc [3];
  logic signed [WW-1:0]   w [3];
  logic signed [23:0]     world [3];
  logic [2:0]             clip;

  // the whole pipeline moves unless the output word is held
  assign en    = !vld[5] || pop;
  assign q_rd  = en && !q_status.empty;
  assign empty = !vld[5];

  assign q_dx = q_data[QW-1 -: DXW];
  assign q_dy = q_data[QW-1-DXW -: DXW];
  assign q_z  = q_data[24 +: DEPTH_BITS];

  // rotation entries and translation, column 0 in the top bits
  always_comb begin
    rot[0][0] = cfg.rotation_row0[47:32];
    rot[0][1] = cfg.rotation_row0[31:16];
    rot[0][2] = cfg.rotation_row0[15:0];
    rot[1][0] = cfg.rotation_row1[47:32];
    rot[1][1] = cfg.rotation_row1[31:16];
    rot[1][2] = cfg.rotation_row1[15:0];
    rot[2][0] = cfg.rotation_row2[47:32];
    rot[2][1] = cfg.rotation_row2[31:16];
    rot[2][2] = cfg.rotation_row2[15:0];
    // t * 2^22 plus the rounding half of the final shift
    tterm[0]  = {cfg.translation_packed[62:42], 1'b1, 21'b0};
    tterm[1]  = {cfg.translation_packed[41:21], 1'b1, 21'b0};
    tterm[2]  = {cfg.translation_packed[20:0], 1'b1, 21'b0};
  end

  // round half up for the camera point
  assign sum_x = $signed({px[PW-1], px}) + CAM_HALF;
  assign sum_y = $signed({py[PW-1], py}) + CAM_HALF;

  // clamp inputs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = acc[i][ACCW-1:22];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], q_rd};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offset times depth
      dzx   <= DZW'(q_dx) * DZW'($signed({1'b0, q_z}));
      dzy   <= DZW'(q_dy) * DZW'($signed({1'b0, q_z}));
      camz1 <= CAMW'($signed({1'b0, q_z, 8'h00}));
      // stage 2: times reciprocal focal length
      px    <= PW'(dzx) * PW'($signed({1'b0, cfg.inv_focal_x}));
      py    <= PW'(dzy) * PW'($signed({1'b0, cfg.inv_focal_y}));
      camz2 <= camz1;
      // stage 3: camera point
      cam[0] <= sum_x[PW:CAM_SHIFT];
      cam[1] <= sum_y[PW:CAM_SHIFT];
      cam[2] <= camz2;
      // stage 4: rotation products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= RPW'(rot[i][j]) * RPW'(cam[j]);
        end
      end
      // stage 5: row sums
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACCW'(prod[i][0]) + ACCW'(prod[i][1]) + ACCW'(prod[i][2]) +
                  ACCW'(tterm[i]);
      end
      // stage 6: clamp into the output register
      for (int i = 0; i < 3; i++) begin
        if (w[i] > W_MAX) begin
          world[i] <= 24'(W_MAX);
          clip[i]  <= 1'b1;
        end else if (w[i] < W_MIN) begin
          world[i] <= 24'(W_MIN);
          clip[i]  <= 1'b1;
        end else begin
          world[i] <= w[i][23:0];
          clip[i]  <= 1'b0;
        end
      end
      // colour travels alongside
      color_pipe[0] <= q_data[23:0];
      for (int k = 1; k < 6; k++) begin
        color_pipe[k] <= color_pipe[k-1];
      end
    end
  end

  assign world_x   = world[0];
  assign world_y   = world[1];
  assign world_z   = world[2];
  assign red_out   = color_pipe[5][23:16];
  assign green_out = color_pipe[5][15:8];
  assign blue_out  = color_pipe[5][7:0];
  assign saturated = |clip;

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while output held");
  a_s5_reaches_out: assert property (@(posedge clk) disable iff (rst)
    en && vld[4] |=> vld[5])
    else $error("word lost between row sum and output");
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    vld[5] && saturated |->
      world_x == 24'(W_MAX) || world_x == 24'(W_MIN) ||
      world_y == 24'(W_MAX) || world_y == 24'(W_MIN) ||
      world_z == 24'(W_MAX) || world_z == 24'(W_MIN))
    else $error("saturated flag without a clamped coordinate");
`endif

endmodule
